// ===== rtl/sbe_pkg.sv =====
// Shared types, constants and the generator step for the shuffle bag engine.
`timescale 1ns / 1ps

package sbe_pkg;

   localparam int BAG_DEPTH = 128;
   localparam int CNT_W     = 8;
   localparam int ADDR_W    = $clog2(BAG_DEPTH);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BAG_DEPTH);
   localparam logic [31:0]      GEN_SEED  = 32'h9E37_79B9;

   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_PUSH    = 2'd1;
   localparam logic [1:0] REQ_SHUFFLE = 2'd2;
   localparam logic [1:0] REQ_DRAW    = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  item;
      logic [31:0] entropy;
   } sbe_req_type;

   typedef struct packed {
      logic [7:0]       drawn_item;
      logic [1:0]       status;
      logic [CNT_W-1:0] fill_count;
   } sbe_rsp_type;

   // One xorshift32 step; a zero result falls back to the seed.
   function automatic logic [31:0] sbe_next(input logic [31:0] s);
      logic [31:0] t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return (t == 32'd0) ? GEN_SEED : t;
   endfunction

endpackage

// ===== rtl/shuffle_bag_engine.sv =====
// Top level of the shuffle bag engine: request sequencer, item memory and modulo unit.
`timescale 1ns / 1ps

// Clear, push, a draw from an empty bag and a shuffle of fewer than two items finish
// in the cycle that accepts them, a draw of a held item in the draw state; the result
// strobe comes the cycle after the request completes and cannot be held off, so take
// it when it shows. A shuffle of n items (n at least two) makes n-1 swaps: each swap
// takes a generator step, then runs the one-bit-per-cycle remainder unit that reduces
// the random word modulo i+1, then accesses the item memory, which has one read and
// one write port (read i, read j, write i, write j). busy stays high while a draw or
// shuffle is in flight.
module shuffle_bag_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sbe_pkg::sbe_req_type req_data,
   output logic                rsp_strobe,
   output sbe_pkg::sbe_rsp_type rsp_data
);
   import sbe_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DRAW = 3'd1;
   localparam logic [2:0] ST_GEN  = 3'd2;
   localparam logic [2:0] ST_MOD  = 3'd3;
   localparam logic [2:0] ST_RDI  = 3'd4;
   localparam logic [2:0] ST_RDJ  = 3'd5;
   localparam logic [2:0] ST_WRI  = 3'd6;
   localparam logic [2:0] ST_WRJ  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       gen_ff, gen_in;
   logic [31:0]       val_ff, val_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [4:0]        bit_ff, bit_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [7:0]        tmp_ff, tmp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   sbe_rsp_type       rsp_ff, rsp_in;

   logic [7:0]        mem [BAG_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   logic              accept;
   logic [CNT_W-1:0]  count_m1;
   logic [31:0]       mixed;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    divisor;
   logic [CNT_W:0]    rem_next;

   assign accept   = start && (state_ff == ST_IDLE);
   assign count_m1 = count_ff - CNT_W'(1);
   assign mixed    = gen_ff ^ req_data.entropy;

   // Remainder step: shift in one bit of the random word, subtract if it fits.
   assign trial    = {rem_ff, val_ff[31]};
   assign divisor  = {1'b0, CNT_W'(i_ff) + CNT_W'(1)};
   assign rem_next = (trial >= divisor) ? (trial - divisor) : trial;

   always_comb begin
      if (state_ff == ST_RDJ) begin
         rd_addr = j_ff;
      end else if (state_ff == ST_IDLE) begin
         rd_addr = count_m1[ADDR_W-1:0];
      end else begin
         rd_addr = i_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      gen_in        = gen_ff;
      val_in        = val_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      tmp_in        = tmp_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff;
      wr_data       = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_CLEAR: begin
                     count_in      = '0;
                     rsp_in        = '{drawn_item: 8'd0, status: STAT_OK, fill_count: '0};
                     rsp_strobe_in = 1'b1;
                  end
                  REQ_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff >= DEPTH_CNT) begin
                        rsp_in = '{drawn_item: 8'd0, status: STAT_FULL, fill_count: count_ff};
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_W-1:0];
                        wr_data  = req_data.item;
                        count_in = count_ff + CNT_W'(1);
                        rsp_in   = '{drawn_item: 8'd0, status: STAT_OK,
                                     fill_count: count_ff + CNT_W'(1)};
                     end
                  end
                  REQ_SHUFFLE: begin
                     gen_in = (mixed == 32'd0) ? GEN_SEED : mixed;
                     if (count_ff < CNT_W'(2)) begin
                        rsp_in        = '{drawn_item: 8'd0, status: STAT_OK,
                                          fill_count: count_ff};
                        rsp_strobe_in = 1'b1;
                     end else begin
                        i_in     = count_m1[ADDR_W-1:0];
                        state_in = ST_GEN;
                     end
                  end
                  REQ_DRAW: begin
                     if (count_ff == '0) begin
                        rsp_in        = '{drawn_item: 8'd0, status: STAT_EMPTY,
                                          fill_count: '0};
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_DRAW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAW: begin
            // Top entry was read on the accept edge.
            count_in      = count_m1;
            rsp_in        = '{drawn_item: rd_data_ff, status: STAT_OK, fill_count: count_m1};
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_GEN: begin
            gen_in   = sbe_next(gen_ff);
            val_in   = sbe_next(gen_ff);
            rem_in   = '0;
            bit_in   = 5'd31;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            val_in = val_ff << 1;
            rem_in = rem_next[CNT_W-1:0];
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               j_in     = rem_next[ADDR_W-1:0];
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            state_in = ST_RDJ;
         end
         ST_RDJ: begin
            // Hold entry i while entry j is fetched.
            tmp_in   = rd_data_ff;
            state_in = ST_WRI;
         end
         ST_WRI: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = rd_data_ff;
            state_in = ST_WRJ;
         end
         ST_WRJ: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = tmp_ff;
            i_in    = i_ff - ADDR_W'(1);
            if (i_ff == ADDR_W'(1)) begin
               rsp_in        = '{drawn_item: 8'd0, status: STAT_OK, fill_count: count_ff};
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_GEN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         gen_ff        <= GEN_SEED;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         gen_ff        <= gen_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      tmp_ff <= tmp_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("fill count above bag depth");

   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_ff != 32'd0)
      else $error("generator state is zero");

   a_j_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDI) |-> (j_ff <= i_ff))
      else $error("swap index out of range");

   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(accept) || $past(state_ff == ST_DRAW) ||
                         $past(state_ff == ST_WRJ)))
      else $error("result strobe without a finishing request");

endmodule
